FILE: rtl/cte_pkg.sv
// Shared constants, types and helpers of the CBOR telemetry record encoder.
package cte_pkg;

    localparam int MAX_KEY_BYTES_DEF = 32;
    localparam int KEY_WORDS         = 4;
    localparam int KEY_BITS          = KEY_WORDS * 64;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] REG_KEY_0_7    = 3'd1;
    localparam logic [2:0] REG_KEY_8_15   = 3'd2;
    localparam logic [2:0] REG_KEY_16_23  = 3'd3;
    localparam logic [2:0] REG_KEY_24_31  = 3'd4;

    // CBOR codes
    localparam logic [7:0] CB_MAP4      = 8'hA4;
    localparam logic [7:0] CB_TEXT8     = 8'h68;
    localparam logic [7:0] CB_TEXT0     = 8'h60;
    localparam logic [7:0] CB_TEXT_LEN8 = 8'h78;
    localparam logic [7:0] CB_TEXT1     = 8'h61;
    localparam logic [7:0] CB_HALF      = 8'hF9;
    localparam logic [7:0] CB_NEG8      = 8'h38;
    localparam logic [7:0] CB_UINT32    = 8'h1A;
    localparam logic [7:0] CH_H         = 8'h68;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_U         = 8'h75;

    localparam logic [15:0] HALF_INF    = 16'h7C00;
    localparam logic [15:0] HALF_SIGN   = 16'h8000;

    // Fixed byte counts of the record
    localparam logic [5:0] PREFIX_BYTES = 6'd10;
    localparam logic [5:0] SHORT_LEN    = 6'd24;
    localparam logic [3:0] TAIL_LAST    = 4'd15;

    typedef struct packed {
        logic [5:0]          key_length;
        logic [KEY_BITS-1:0] key_text;
    } t_key_cfg;

    typedef struct packed {
        logic [15:0] half_float;
        logic [7:0]  signal_byte;
        logic [31:0] uptime;
    } t_record;

    // Map header, first key text header and the fixed eight-byte key name
    function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = CB_MAP4;
            4'd1:    b = CB_TEXT8;
            4'd2:    b = 8'h70;
            4'd3:    b = 8'h72;
            4'd4:    b = 8'h6F;
            4'd5:    b = 8'h76;
            4'd6:    b = 8'h5F;
            4'd7:    b = 8'h6B;
            4'd8:    b = 8'h65;
            4'd9:    b = 8'h79;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Single to half: truncated mantissa, flush to signed zero, saturate to infinity
    function automatic logic [15:0] to_half(input logic [31:0] x);
        logic [7:0]  e;
        logic [7:0]  eb;
        logic [15:0] s;
        e  = x[30:23];
        eb = e - 8'd112;
        s  = {x[31], 15'd0};
        if (e <= 8'd112)
            return s;
        else if (e >= 8'd143)
            return s | HALF_INF;
        else
            return {x[31], eb[4:0], x[22:13]};
    endfunction

    function automatic logic [7:0] tail_byte(input logic [3:0] idx, input t_record rec);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = CB_TEXT1;
            4'd1:    b = CH_H;
            4'd2:    b = CB_HALF;
            4'd3:    b = rec.half_float[15:8];
            4'd4:    b = rec.half_float[7:0];
            4'd5:    b = CB_TEXT1;
            4'd6:    b = CH_R;
            4'd7:    b = CB_NEG8;
            4'd8:    b = rec.signal_byte;
            4'd9:    b = CB_TEXT1;
            4'd10:   b = CH_U;
            4'd11:   b = CB_UINT32;
            4'd12:   b = rec.uptime[31:24];
            4'd13:   b = rec.uptime[23:16];
            4'd14:   b = rec.uptime[15:8];
            4'd15:   b = rec.uptime[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/cte_apb_regs.sv
// Configuration registers behind the APB-style port.
module cte_apb_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [5:0]        paddr,
    input  logic [63:0]       pwdata,
    output logic [63:0]       prdata,
    output logic              pready,
    output cte_pkg::t_key_cfg o_cfg
);
    import cte_pkg::*;

    logic [5:0]  r_key_length;
    logic [63:0] r_key [KEY_WORDS];
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= '0;
            for (int k = 0; k < KEY_WORDS; k++) r_key[k] <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_KEY_LENGTH: r_key_length <= pwdata[5:0];
                REG_KEY_0_7:    r_key[0]     <= pwdata;
                REG_KEY_8_15:   r_key[1]     <= pwdata;
                REG_KEY_16_23:  r_key[2]     <= pwdata;
                REG_KEY_24_31:  r_key[3]     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KEY_LENGTH: prdata = {58'd0, r_key_length};
            REG_KEY_0_7:    prdata = r_key[0];
            REG_KEY_8_15:   prdata = r_key[1];
            REG_KEY_16_23:  prdata = r_key[2];
            REG_KEY_24_31:  prdata = r_key[3];
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.key_length = r_key_length;
    assign o_cfg.key_text   = {r_key[3], r_key[2], r_key[1], r_key[0]};

endmodule

FILE: rtl/cte_byte_seq.sv
// Record register, byte counter and output register of the encoder.
module cte_byte_seq #(
    parameter int MAX_KEY_BYTES = cte_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cte_pkg::t_key_cfg i_cfg,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [71:0]       s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,
    output logic              m_axis_tlast
);
    import cte_pkg::*;

    logic       r_busy;
    logic [5:0] r_pos;
    t_record    r_rec;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [5:0] len_s;
    logic [5:0] key_start;
    logic [5:0] tail_start;
    logic [5:0] key_off;
    logic [5:0] tail_off;
    logic [7:0] n_byte;
    logic       n_last;
    logic       step;
    logic       accept;

    assign len_s      = (i_cfg.key_length > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES)
                                                              : i_cfg.key_length;
    assign key_start  = (len_s < SHORT_LEN) ? PREFIX_BYTES + 6'd1 : PREFIX_BYTES + 6'd2;
    assign tail_start = key_start + len_s;
    assign key_off    = r_pos - key_start;
    assign tail_off   = r_pos - tail_start;

    always_comb begin
        n_last = 1'b0;
        priority if (r_pos < PREFIX_BYTES) begin
            n_byte = prefix_byte(r_pos[3:0]);
        end else if (r_pos < key_start) begin
            if (len_s < SHORT_LEN)
                n_byte = CB_TEXT0 | {2'b00, len_s};
            else if (r_pos == PREFIX_BYTES)
                n_byte = CB_TEXT_LEN8;
            else
                n_byte = {2'b00, len_s};
        end else if (r_pos < tail_start) begin
            n_byte = i_cfg.key_text[{key_off[4:0], 3'b000} +: 8];
        end else begin
            n_byte = tail_byte(tail_off[3:0], r_rec);
            n_last = (tail_off[3:0] == TAIL_LAST);
        end
    end

    // Move one byte into the output register while busy, whenever it is free or being drained
    assign step          = r_busy & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_busy | (step & n_last);
    assign accept        = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step && n_last) begin
                r_pos  <= '0;
                r_busy <= accept;
            end else if (step) begin
                r_pos <= r_pos + 6'd1;
            end else if (accept) begin
                r_busy <= 1'b1;
            end

            if (step)
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rec.half_float  <= to_half(s_axis_tdata[31:0]);
            r_rec.signal_byte <= ~s_axis_tdata[39:32];
            r_rec.uptime      <= s_axis_tdata[71:40];
        end
        if (step) begin
            r_out_byte <= n_byte;
            r_out_last <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: rtl/cbor_telemetry_record_encoder_top.sv
// Top level of the CBOR telemetry record encoder.
// An accepted item first sets the busy flag; the first byte of the record then goes into the output register.
// Throughput: one byte per cycle from the output register while m_axis_tready is high; a record is
//   27 + len bytes for a key shorter than 24 bytes and 28 + len otherwise (60 at most).
// The next item is taken on the cycle the last byte of the current record is loaded.
// Reset is synchronous, active low; it clears the sequencer and the key registers.
module cbor_telemetry_record_encoder_top #(
    parameter int MAX_KEY_BYTES = cte_pkg::MAX_KEY_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // humidity_bits [31:0], signal_strength [39:32], uptime_seconds [71:40]
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte [7:0]
    output logic [7:0]  m_axis_tdata,
    // last_byte
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import cte_pkg::*;

    t_key_cfg key_cfg;

    cte_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (key_cfg)
    );

    cte_byte_seq #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (key_cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: rtl/cte_checker.sv
// Port-level checks of the encoder, bound to the top level.
module cte_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       pready
);
    import cte_pkg::*;

    // Output register comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A stalled byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output byte changed");

    // Every record opens with the four-pair map header
    a_map_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
            !m_axis_tvalid || m_axis_tdata == CB_MAP4)
        else $error("record does not open with map header");

    // A fresh record is being sent, so no item is taken in the next cycle
    a_no_back_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready straight after an item was taken");

    // Configuration port never stalls
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("configuration port not ready");

endmodule

bind cbor_telemetry_record_encoder_top cte_checker u_cte_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .pready        (pready)
);

FILE: verif/tb_cbor_telemetry_record_encoder_top.sv
// Self-checking testbench of the CBOR telemetry record encoder: directed table, then random records.
module tb_cbor_telemetry_record_encoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cte_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // humidity_bits [31:0], signal_strength [39:32], uptime_seconds [71:40]
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // out_byte [7:0]
    logic [7:0]  m_axis_tdata;
    // last_byte
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    cbor_telemetry_record_encoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    typedef struct packed {
        logic [7:0] data;
        logic       is_last;
    } t_map_byte;

    typedef struct packed {
        logic [31:0] hum;
        logic [7:0]  sig;
        logic [31:0] up;
        bit          typed;
        logic [15:0] half;
        logic [7:0]  sig_byte;
    } t_dir_row;

    localparam int DIR_ROWS = 19;

    // half and signal byte are typed in only where typed is set
    t_dir_row dir_rows [0:DIR_ROWS-1] = '{
        '{32'h0000_0000, 8'hFF, 32'h0000_0000, 1'b1, 16'h0000, 8'h00},
        '{32'h8000_0000, 8'h80, 32'hFFFF_FFFF, 1'b1, 16'h8000, 8'h7F},
        '{32'h7F80_0000, 8'hFF, 32'h0000_0001, 1'b1, 16'h7C00, 8'h00},
        '{32'hFF80_0000, 8'h80, 32'h8000_0000, 1'b1, 16'hFC00, 8'h7F},
        '{32'h7FC0_0001, 8'hC0, 32'h1234_5678, 1'b1, 16'h7C00, 8'h3F},
        '{32'hFFFF_FFFF, 8'h00, 32'h0000_0000, 1'b1, 16'hFC00, 8'hFF},
        '{32'h3F80_0000, 8'h7F, 32'hA5A5_A5A5, 1'b1, 16'h3C00, 8'h80},
        '{32'h477F_E000, 8'h01, 32'h5A5A_5A5A, 1'b1, 16'h7BFF, 8'hFE},
        '{32'h4780_0000, 8'hFE, 32'hDEAD_BEEF, 1'b1, 16'h7C00, 8'h01},
        '{32'hC780_0000, 8'h9C, 32'h0000_FFFF, 1'b1, 16'hFC00, 8'h63},
        '{32'h3880_0000, 8'hFF, 32'hFFFF_0000, 1'b1, 16'h0400, 8'h00},
        '{32'hB880_0000, 8'h80, 32'h0102_0304, 1'b1, 16'h8400, 8'h7F},
        '{32'h3800_0000, 8'hF0, 32'h8000_0001, 1'b1, 16'h0000, 8'h0F},
        '{32'hB87F_FFFF, 8'h81, 32'h7FFF_FFFE, 1'b1, 16'h8000, 8'h7E},
        '{32'h0000_0001, 8'hFF, 32'h0000_0000, 1'b1, 16'h0000, 8'h00},
        '{32'h7F7F_FFFF, 8'h80, 32'hFFFF_FFFF, 1'b1, 16'h7C00, 8'h7F},
        '{32'h42C8_0000, 8'hC4, 32'h0001_5180, 1'b0, 16'h0000, 8'h00},
        '{32'hC120_0000, 8'hAB, 32'h0BAD_F00D, 1'b0, 16'h0000, 8'h00},
        '{32'h3EAA_AAAB, 8'h40, 32'h3333_CCCC, 1'b0, 16'h0000, 8'h00}
    };

    // Copy of the key registers as the block should hold them
    logic [5:0]      key_len_cfg;
    logic [KEY_BITS-1:0] key_text_cfg;

    t_map_byte   pending_bytes [$];
    int          mismatches;
    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;

    function automatic logic [15:0] single_to_half(input logic [31:0] f);
        int          ex;
        logic [15:0] sgn;
        sgn = {f[31], 15'd0};
        ex  = int'(f[30:23]) - 127 + 15;
        if (ex <= 0)
            return sgn;
        if (ex >= 31)
            return sgn | HALF_INF;
        return {f[31], ex[4:0], f[22:13]};
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        pending_bytes.push_back('{data: b, is_last: 1'b0});
    endfunction

    // Queue up the whole encoded map of one record
    function automatic void predict_record(input logic [31:0] hum, input logic [7:0] sig,
                                           input logic [31:0] up, input bit typed,
                                           input logic [15:0] t_half, input logic [7:0] t_sig);
        logic [63:0] tag;
        logic [15:0] half;
        logic [7:0]  sig_byte;
        int          len;
        t_map_byte   tail;
        // fixed key name, first character in the top byte
        tag      = 64'h7072_6F76_5F6B_6579;
        half     = typed ? t_half : single_to_half(hum);
        sig_byte = typed ? t_sig : ~sig;
        len      = (key_len_cfg > 6'd32) ? 32 : int'(key_len_cfg);
        push_byte(CB_MAP4);
        push_byte(CB_TEXT8);
        for (int i = 0; i < 8; i++)
            push_byte(tag[63-8*i -: 8]);
        if (len < 24) begin
            push_byte(CB_TEXT0 | 8'(len));
        end else begin
            push_byte(CB_TEXT_LEN8);
            push_byte(8'(len));
        end
        for (int i = 0; i < len; i++)
            push_byte(key_text_cfg[8*i +: 8]);
        push_byte(CB_TEXT1);
        push_byte(CH_H);
        push_byte(CB_HALF);
        push_byte(half[15:8]);
        push_byte(half[7:0]);
        push_byte(CB_TEXT1);
        push_byte(CH_R);
        push_byte(CB_NEG8);
        push_byte(sig_byte);
        push_byte(CB_TEXT1);
        push_byte(CH_U);
        push_byte(CB_UINT32);
        push_byte(up[31:24]);
        push_byte(up[23:16]);
        push_byte(up[15:8]);
        tail = '{data: up[7:0], is_last: 1'b1};
        pending_bytes.push_back(tail);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver side: ready decided afresh at every falling edge
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_map_byte want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected byte %02h last %b", m_axis_tdata, m_axis_tlast);
            end else begin
                want = pending_bytes.pop_front();
                if (m_axis_tdata !== want.data || m_axis_tlast !== want.is_last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: byte exp %02h got %02h, last exp %b got %b",
                                 want.data, m_axis_tdata, want.is_last, m_axis_tlast);
                end
            end
        end
    end

    task automatic idle_sender();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_record(input logic [31:0] hum, input logic [7:0] sig,
                               input logic [31:0] up, input bit typed,
                               input logic [15:0] t_half, input logic [7:0] t_sig);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {up, sig, hum};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_record(hum, sig, up, typed, t_half, t_sig);
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_KEY_LENGTH: key_len_cfg = val[5:0];
            REG_KEY_0_7:    key_text_cfg[63:0]    = val;
            REG_KEY_8_15:   key_text_cfg[127:64]  = val;
            REG_KEY_16_23:  key_text_cfg[191:128] = val;
            REG_KEY_24_31:  key_text_cfg[255:192] = val;
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_key(input logic [5:0] len, input logic [63:0] w0, input logic [63:0] w1,
                           input logic [63:0] w2, input logic [63:0] w3);
        idle_sender();
        wait_drained();
        reg_write(REG_KEY_LENGTH, {58'd0, len});
        reg_write(REG_KEY_0_7, w0);
        reg_write(REG_KEY_8_15, w1);
        reg_write(REG_KEY_16_23, w2);
        reg_write(REG_KEY_24_31, w3);
    endtask

    function automatic logic [63:0] rand_key_word();
        case ($urandom_range(5))
            0:       return 64'd0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [5:0] rand_key_len();
        case ($urandom_range(6))
            0:       return 6'd0;
            1:       return 6'd23;
            2:       return 6'd24;
            3:       return 6'd32;
            4:       return 6'd33;
            5:       return 6'd63;
            default: return 6'($urandom_range(1, 63));
        endcase
    endfunction

    // Biased towards exponents at the underflow and overflow edges of the half format
    function automatic logic [31:0] rand_humidity();
        logic [7:0] ex;
        case ($urandom_range(3))
            0: ex = 8'($urandom_range(108, 116));
            1: ex = 8'($urandom_range(139, 147));
            2: ex = 8'($urandom_range(113, 142));
            default: ex = $urandom_range(1) ? 8'hFF : 8'h00;
        endcase
        if ($urandom_range(3) == 0)
            return $urandom;
        return {1'($urandom), ex, 23'($urandom)};
    endfunction

    function automatic logic [7:0] rand_signal();
        if ($urandom_range(9) == 0)
            return 8'($urandom);
        return 8'(256 - $urandom_range(1, 128));
    endfunction

    function automatic logic [31:0] rand_uptime();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int guard;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        key_len_cfg   = '0;
        key_text_cfg  = '0;
        mismatches    = 0;
        snd_idle_pct  = 38;
        rcv_idle_pct  = 75;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset key first, then a 24-byte key with zero bytes, then a saturated length
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (r == 7)
                set_key(6'd24, 64'd0, 64'h6F6C_6C65_6800_0041, '1, 64'h1234_5678_9ABC_DEF0);
            if (r == 13)
                set_key(6'd63, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                        64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE);
            send_record(dir_rows[r].hum, dir_rows[r].sig, dir_rows[r].up,
                        dir_rows[r].typed, dir_rows[r].half, dir_rows[r].sig_byte);
        end

        for (int m = 0; m < 3; m++) begin
            snd_idle_pct = (m == 0) ? 38 : (m == 1) ? 75 : 0;
            rcv_idle_pct = (m == 0) ? 75 : (m == 1) ? 38 : 0;
            for (int c = 0; c < 3; c++) begin
                set_key(rand_key_len(), rand_key_word(), rand_key_word(), rand_key_word(),
                        rand_key_word());
                for (int n = 0; n < 17; n++) begin
                    // hold off now and then until the encoder has emptied
                    if (n == 3 || $urandom_range(24) == 0) begin
                        idle_sender();
                        wait_drained();
                    end
                    send_record(rand_humidity(), rand_signal(), rand_uptime(), 1'b0, '0, '0);
                end
            end
        end

        idle_sender();
        guard = 0;
        while (pending_bytes.size() != 0 && guard < 200_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (30) @(posedge i_clk);
        mismatches += pending_bytes.size();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
